// File: rtl/msam_pkg.sv
// Shared types, constants and sample conversion functions for the audio mixer.
// No dependencies; used by msam_ctrl, msam_dp and multi_source_audio_mixer.
`timescale 1ns / 1ps

package msam_pkg;

    localparam int NUM_SOURCES_DEF = 4;
    localparam int RING_DEPTH_DEF  = 4096;

    localparam logic [20:0] RATIO_RESET = 21'd65536;
    localparam logic [20:0] RATIO_MAX   = 21'd1048576;
    localparam logic [20:0] CREDIT_ONE  = 21'd65536;

    localparam logic [2:0] REG_RATIO0  = 3'd0;
    localparam logic [2:0] REG_RATIO1  = 3'd1;
    localparam logic [2:0] REG_RATIO2  = 3'd2;
    localparam logic [2:0] REG_RATIO3  = 3'd3;
    localparam logic [2:0] REG_FLOAT   = 3'd4;
    localparam logic [2:0] REG_MONO    = 3'd5;
    localparam logic [2:0] REG_ACTIVE  = 3'd6;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CREDIT = 6'b000010,
        ST_PUT    = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_ACC    = 6'b010000,
        ST_OUT    = 6'b100000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_item;   // capture input item, convert samples
        logic add_credit;  // add ratio to credit of current source
        logic put;         // write one frame, subtract one credit
        logic clr_sum;     // zero the mix accumulators
        logic rd_issue;    // read ring head of scan source, pop it
        logic acc;         // add read data to accumulators
        logic out_load;    // load output register from accumulators
        logic [1:0] scan;  // scan source index
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic op;          // captured operation
        logic src_ok;      // pushed source active and present
        logic credit_ge;   // credit of current source >= one
        logic scan_ok;     // scan source active and non-empty
        logic out_full;    // output register holds an untaken result
    } t_sts;

    // Signed 16-bit field to Q2.15
    function automatic logic signed [16:0] s16_to_q(input logic [31:0] bits);
        s16_to_q = {bits[15], bits[15:0]};
    endfunction

    // IEEE single to Q2.15, clamp to +-1, round half to even, NaN to zero
    function automatic logic signed [16:0] f32_to_q(input logic [31:0] bits);
        logic        neg;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [23:0] sig;
        logic [7:0]  shift;
        logic [23:0] q;
        logic [48:0] ext;
        logic [24:0] rem;
        logic [24:0] half;
        logic [16:0] mag;
        neg   = bits[31];
        ex    = bits[30:23];
        man   = bits[22:0];
        sig   = (ex != 8'd0) ? {1'b1, man} : {1'b0, man};
        shift = 8'd135 - ((ex != 8'd0) ? ex : 8'd1);
        mag   = 17'd0;
        if (ex == 8'hFF && man != 23'd0) begin
            mag = 17'd0;
        end else if (ex >= 8'd127) begin
            mag = 17'd32768;
        end else if (shift > 8'd25) begin
            mag = 17'd0;
        end else begin
            ext  = {sig, 25'd0} >> shift;
            q    = ext[48:25];
            rem  = ext[24:0];
            half = 25'h1000000;
            if (rem > half || (rem == half && q[0]))
                q = q + 24'd1;
            mag = q[16:0];
        end
        f32_to_q = neg ? -$signed(mag) : $signed(mag);
    endfunction

    // Clamp a sum to +-1 and scale by 32767/32768, ties to even
    function automatic logic signed [15:0] mix_out(input logic signed [18:0] sum);
        logic signed [18:0] c;
        logic [15:0] mag;
        logic [30:0] a;
        logic [15:0] q;
        logic [14:0] r;
        c = sum;
        if (sum > 19'sd32768)
            c = 19'sd32768;
        if (sum < -19'sd32768)
            c = -19'sd32768;
        mag = c[18] ? 16'(-c) : 16'(c);
        a = 31'(mag) * 31'd32767;
        q = a[30:15];
        r = a[14:0];
        if (r > 15'h4000 || (r == 15'h4000 && q[0]))
            q = q + 16'd1;
        mix_out = c[18] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// File: rtl/msam_ctrl.sv
// Controller state machine of the audio mixer: sequences push and render work.
// Depends on msam_pkg; drives msam_dp through command and status structs.
`timescale 1ns / 1ps

module msam_ctrl #(
    parameter int NUM_SOURCES = msam_pkg::NUM_SOURCES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  msam_pkg::t_sts    i_sts,
    output msam_pkg::t_cmd    o_cmd
);

    msam_pkg::t_state r_state, n_state;
    logic [1:0] r_scan, n_scan;

    // Hold scan index and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msam_pkg::ST_IDLE;
            r_scan  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
        end
    end

    assign o_in_ready = (r_state == msam_pkg::ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        o_cmd   = '0;
        o_cmd.scan = r_scan;
        unique case (r_state)
            msam_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = msam_pkg::ST_CREDIT;
                end
            end
            msam_pkg::ST_CREDIT: begin
                if (i_sts.op == msam_pkg::OP_RENDER) begin
                    o_cmd.clr_sum = 1'b1;
                    n_scan  = 2'd0;
                    n_state = msam_pkg::ST_SCAN;
                end else if (i_sts.src_ok) begin
                    o_cmd.add_credit = 1'b1;
                    n_state = msam_pkg::ST_PUT;
                end else begin
                    n_state = msam_pkg::ST_IDLE;
                end
            end
            msam_pkg::ST_PUT: begin
                if (i_sts.credit_ge)
                    o_cmd.put = 1'b1;
                else
                    n_state = msam_pkg::ST_IDLE;
            end
            msam_pkg::ST_SCAN: begin
                if (i_sts.scan_ok) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = msam_pkg::ST_ACC;
                end else if (32'(r_scan) == NUM_SOURCES - 1) begin
                    n_state = msam_pkg::ST_OUT;
                end else begin
                    n_scan = r_scan + 2'd1;
                end
            end
            msam_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
                if (32'(r_scan) == NUM_SOURCES - 1) begin
                    n_state = msam_pkg::ST_OUT;
                end else begin
                    n_scan  = r_scan + 2'd1;
                    n_state = msam_pkg::ST_SCAN;
                end
            end
            msam_pkg::ST_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = msam_pkg::ST_IDLE;
                end
            end
            default: n_state = msam_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: rtl/msam_dp.sv
// Datapath of the audio mixer: config registers, ring pointers, sample store,
// credit accumulators, mix accumulators and output register. Depends on msam_pkg.
`timescale 1ns / 1ps

module msam_dp #(
    parameter int NUM_SOURCES = msam_pkg::NUM_SOURCES_DEF,
    parameter int RING_DEPTH  = msam_pkg::RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  msam_pkg::t_cmd    i_cmd,
    output msam_pkg::t_sts    o_sts,
    input  logic [66:0]       i_in_tdata,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_wdata,
    output logic [31:0]       o_cfg_rdata,
    output logic              o_out_tvalid,
    input  logic              i_out_tready,
    output logic [31:0]       o_out_tdata
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int SW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int AW = PW + SW;

    logic [20:0] r_ratio [4];
    logic [3:0]  r_float, r_mono, r_active;

    logic [PW-1:0] r_rd_ptr [NUM_SOURCES];
    logic [PW-1:0] r_wr_ptr [NUM_SOURCES];
    logic [PW:0]   r_fill   [NUM_SOURCES];
    logic [20:0]   r_credit [NUM_SOURCES];

    logic [33:0] r_mem [NUM_SOURCES * RING_DEPTH];
    logic [33:0] r_rd_data;

    logic        r_op;
    logic [1:0]  r_src;
    logic signed [16:0] r_l, r_r;
    logic signed [18:0] r_sum_l, r_sum_r;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic [31:0] lbits, rbits;
    logic [SW-1:0] src_i, scan_i;
    logic [20:0] ratio_sat;
    logic [20:0] ratio_sel;
    logic        src_present;
    logic        scan_present;

    assign lbits = i_in_tdata[34:3];
    assign rbits = i_in_tdata[66:35];
    assign src_i  = SW'(r_src);
    assign scan_i = SW'(i_cmd.scan);
    assign src_present  = 32'(r_src) < NUM_SOURCES;
    assign scan_present = 32'(i_cmd.scan) < NUM_SOURCES;
    assign ratio_sel = r_ratio[r_src];
    assign ratio_sat = (ratio_sel > msam_pkg::RATIO_MAX) ? msam_pkg::RATIO_MAX : ratio_sel;

    // Register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_ratio[k] <= msam_pkg::RATIO_RESET;
            r_float  <= 4'd0;
            r_mono   <= 4'd0;
            r_active <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                msam_pkg::REG_RATIO0: r_ratio[0] <= i_cfg_wdata[20:0];
                msam_pkg::REG_RATIO1: r_ratio[1] <= i_cfg_wdata[20:0];
                msam_pkg::REG_RATIO2: r_ratio[2] <= i_cfg_wdata[20:0];
                msam_pkg::REG_RATIO3: r_ratio[3] <= i_cfg_wdata[20:0];
                msam_pkg::REG_FLOAT:  r_float  <= i_cfg_wdata[3:0];
                msam_pkg::REG_MONO:   r_mono   <= i_cfg_wdata[3:0];
                msam_pkg::REG_ACTIVE: r_active <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (i_cfg_idx)
            msam_pkg::REG_RATIO0: o_cfg_rdata = 32'(r_ratio[0]);
            msam_pkg::REG_RATIO1: o_cfg_rdata = 32'(r_ratio[1]);
            msam_pkg::REG_RATIO2: o_cfg_rdata = 32'(r_ratio[2]);
            msam_pkg::REG_RATIO3: o_cfg_rdata = 32'(r_ratio[3]);
            msam_pkg::REG_FLOAT:  o_cfg_rdata = 32'(r_float);
            msam_pkg::REG_MONO:   o_cfg_rdata = 32'(r_mono);
            msam_pkg::REG_ACTIVE: o_cfg_rdata = 32'(r_active);
            default:              o_cfg_rdata = 32'd0;
        endcase
    end

    // Capture item and convert samples
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            logic [31:0] rsel;
            logic [1:0]  s;
            s    = i_in_tdata[2:1];
            rsel = r_mono[s] ? lbits : rbits;
            r_op  <= i_in_tdata[0];
            r_src <= s;
            if (r_float[s]) begin
                r_l <= msam_pkg::f32_to_q(lbits);
                r_r <= msam_pkg::f32_to_q(rsel);
            end else begin
                r_l <= msam_pkg::s16_to_q(lbits);
                r_r <= msam_pkg::s16_to_q(rsel);
            end
        end
    end

    // Ring pointers, fill counts and credit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SOURCES; k++) begin
                r_rd_ptr[k] <= '0;
                r_wr_ptr[k] <= '0;
                r_fill[k]   <= '0;
                r_credit[k] <= '0;
            end
        end else begin
            if (i_cfg_we && i_cfg_idx == msam_pkg::REG_ACTIVE) begin
                for (int k = 0; k < NUM_SOURCES; k++) begin
                    if (r_active[k] && !i_cfg_wdata[k]) begin
                        r_rd_ptr[k] <= '0;
                        r_wr_ptr[k] <= '0;
                        r_fill[k]   <= '0;
                        r_credit[k] <= '0;
                    end
                end
            end
            if (i_cmd.add_credit)
                r_credit[src_i] <= r_credit[src_i] + ratio_sat;
            if (i_cmd.put) begin
                r_credit[src_i] <= r_credit[src_i] - msam_pkg::CREDIT_ONE;
                r_wr_ptr[src_i] <= r_wr_ptr[src_i] + PW'(1);
                if (r_fill[src_i] == (PW+1)'(RING_DEPTH))
                    r_rd_ptr[src_i] <= r_rd_ptr[src_i] + PW'(1);
                else
                    r_fill[src_i] <= r_fill[src_i] + (PW+1)'(1);
            end
            if (i_cmd.rd_issue) begin
                r_rd_ptr[scan_i] <= r_rd_ptr[scan_i] + PW'(1);
                r_fill[scan_i]   <= r_fill[scan_i] - (PW+1)'(1);
            end
        end
    end

    // Sample store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.put)
            r_mem[{src_i, r_wr_ptr[src_i]}] <= {r_r, r_l};
        if (i_cmd.rd_issue)
            r_rd_data <= r_mem[AW'({scan_i, r_rd_ptr[scan_i]})];
    end

    // Mix accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_sum) begin
            r_sum_l <= '0;
            r_sum_r <= '0;
        end else if (i_cmd.acc) begin
            r_sum_l <= r_sum_l + 19'($signed(r_rd_data[16:0]));
            r_sum_r <= r_sum_r + 19'($signed(r_rd_data[33:17]));
        end
    end

    // Output register, parts the mixer from the output channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load)
            r_out_data <= {msam_pkg::mix_out(r_sum_r), msam_pkg::mix_out(r_sum_l)};
    end

    assign o_out_tvalid = r_out_valid;
    assign o_out_tdata  = r_out_data;

    assign o_sts.op        = r_op;
    assign o_sts.src_ok    = src_present && r_active[r_src];
    assign o_sts.credit_ge = r_credit[src_i] >= msam_pkg::CREDIT_ONE;
    assign o_sts.scan_ok   = scan_present && r_active[i_cmd.scan] && (r_fill[scan_i] != '0);
    assign o_sts.out_full  = r_out_valid && !i_out_tready;

endmodule

// File: rtl/multi_source_audio_mixer.sv
// Top level of the four-source stereo audio mixer with rate-converting rings.
// Depends on msam_pkg, msam_ctrl and msam_dp.
//
//  channel    direction  handshake              payload
//  s_axis     in         tvalid/tready          tdata: operation, source, left, right
//  m_axis     out        tvalid/tready          tdata: out_left, out_right
//  apb        in         psel/penable/pwrite    paddr, pwdata, prdata
//
// A push to a closed source returns to idle from the credit state; an open one adds
// credit, then writes its frames (up to 16 at the top ratio) one at a time through
// the single store write port. A render takes one scan step per source and an
// accumulate step per popped ring, through the store read port.
// Reset is synchronous; the store is not cleared. The output register lets a
// new item enter while a result waits; a render stalls only if one still waits.
`timescale 1ns / 1ps

module multi_source_audio_mixer #(
    parameter int NUM_SOURCES = msam_pkg::NUM_SOURCES_DEF,
    parameter int RING_DEPTH  = msam_pkg::RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[0], source[2:1], left_sample[34:3], right_sample[66:35], zeros
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_left[15:0], out_right[31:16]
    output logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    msam_pkg::t_cmd cmd;
    msam_pkg::t_sts sts;
    logic cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    msam_ctrl #(.NUM_SOURCES(NUM_SOURCES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    msam_dp #(.NUM_SOURCES(NUM_SOURCES), .RING_DEPTH(RING_DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_tdata   (s_axis_tdata[66:0]),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (paddr[4:2]),
        .i_cfg_wdata  (pwdata),
        .o_cfg_rdata  (prdata),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .o_out_tdata  (m_axis_tdata)
    );

endmodule

// File: dv/msam_mix_checker.sv
// Checker for the four-source audio mixer: watches the input, output and register channels,
// predicts each mixed output frame and compares it field by field. Depends on msam_pkg.
`timescale 1ns / 1ps

module msam_mix_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_frames_seen
);

    localparam int DEPTH = msam_pkg::RING_DEPTH_DEF;

    typedef struct packed {
        logic signed [15:0] right;
        logic signed [15:0] left;
    } t_mix_frame;

    // Shadow registers and ring state
    logic [20:0] ratio_q[4];
    logic [3:0]  float_q, mono_q, active_q;
    logic signed [16:0] ring_l[4][DEPTH];
    logic signed [16:0] ring_r[4][DEPTH];
    int unsigned rd_ptr[4], wr_ptr[4], fill[4], credit[4];
    t_mix_frame  mix_queue[$];

    // Signed 16-bit sample to Q2.15
    function automatic logic signed [16:0] pcm_to_q(logic [31:0] b);
        logic signed [15:0] v;
        v = b[15:0];
        return 17'(v);
    endfunction

    // IEEE single to Q2.15 with clamp and round half to even
    function automatic logic signed [16:0] float_to_q(logic [31:0] b);
        int unsigned ex, man, sig, sh, q, rem, half;
        ex  = 32'(b[30:23]);
        man = 32'(b[22:0]);
        if (ex == 255 && man != 0) return 17'sd0;
        if (ex >= 127) begin
            q = 32768;
        end else begin
            sig = (ex != 0) ? (man | 32'h800000) : man;
            sh  = 135 - ((ex != 0) ? ex : 1);
            if (sh > 25) begin
                q = 0;
            end else begin
                q    = sig >> sh;
                rem  = sig & ((32'd1 << sh) - 1);
                half = 32'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0])) q++;
            end
        end
        return b[31] ? -17'(q) : 17'(q);
    endfunction

    // Clamp the mixed sum to +-1 and scale by 32767/32768
    function automatic logic signed [15:0] scale_mix(int sum);
        int c;
        int unsigned a, q, r;
        c = sum;
        if (c > 32768) c = 32768;
        if (c < -32768) c = -32768;
        a = 32'((c < 0) ? -c : c) * 32767;
        q = a >> 15;
        r = a & 32'h7FFF;
        if (r > 32'h4000 || (r == 32'h4000 && q[0])) q++;
        return (c < 0) ? -16'(q) : 16'(q);
    endfunction

    function automatic void clear_source(int s);
        rd_ptr[s] = 0; wr_ptr[s] = 0; fill[s] = 0; credit[s] = 0;
    endfunction

    // Apply one pushed frame through the credit accumulator
    function automatic void push_frame(int s, logic [31:0] lb, logic [31:0] rb);
        logic signed [16:0] l, r;
        int unsigned ratio;
        if (!active_q[s]) return;
        if (mono_q[s]) rb = lb;
        l = float_q[s] ? float_to_q(lb) : pcm_to_q(lb);
        r = float_q[s] ? float_to_q(rb) : pcm_to_q(rb);
        ratio = 32'((ratio_q[s] > msam_pkg::RATIO_MAX) ? msam_pkg::RATIO_MAX : ratio_q[s]);
        credit[s] += ratio;
        while (credit[s] >= 65536) begin
            if (fill[s] >= DEPTH) begin
                rd_ptr[s] = (rd_ptr[s] + 1) % DEPTH;
                fill[s]--;
            end
            ring_l[s][wr_ptr[s]] = l;
            ring_r[s][wr_ptr[s]] = r;
            wr_ptr[s] = (wr_ptr[s] + 1) % DEPTH;
            fill[s]++;
            credit[s] -= 65536;
        end
    endfunction

    // Pop every active non-empty ring and predict the mixed frame
    function automatic t_mix_frame render_frame();
        int sl, sr;
        t_mix_frame f;
        sl = 0; sr = 0;
        for (int k = 0; k < 4; k++) begin
            if (active_q[k] && fill[k] != 0) begin
                sl += int'(ring_l[k][rd_ptr[k]]);
                sr += int'(ring_r[k][rd_ptr[k]]);
                rd_ptr[k] = (rd_ptr[k] + 1) % DEPTH;
                fill[k]--;
            end
        end
        f.left  = scale_mix(sl);
        f.right = scale_mix(sr);
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_mix_frame got, want;
        if (!i_rst_n) begin
            for (int s = 0; s < 4; s++) begin
                ratio_q[s] = msam_pkg::RATIO_RESET;
                clear_source(s);
            end
            float_q = '0; mono_q = '0; active_q = '0;
            mix_queue.delete();
            o_fail_count <= 0;
            o_frames_seen <= 0;
        end else begin
            // Register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    msam_pkg::REG_RATIO0, msam_pkg::REG_RATIO1,
                    msam_pkg::REG_RATIO2, msam_pkg::REG_RATIO3:
                        ratio_q[paddr[3:2]] = pwdata[20:0];
                    msam_pkg::REG_FLOAT: float_q = pwdata[3:0];
                    msam_pkg::REG_MONO:  mono_q  = pwdata[3:0];
                    msam_pkg::REG_ACTIVE: begin
                        for (int s = 0; s < 4; s++)
                            if (active_q[s] && !pwdata[s]) clear_source(s);
                        active_q = pwdata[3:0];
                    end
                    default: ;
                endcase
            end
            // Input transfers
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tdata[0] == msam_pkg::OP_PUSH)
                    push_frame(int'(s_axis_tdata[2:1]), s_axis_tdata[34:3],
                               s_axis_tdata[66:35]);
                else
                    mix_queue.push_back(render_frame());
            end
            // Output transfers
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                o_frames_seen <= o_frames_seen + 1;
                if (mix_queue.size() == 0) begin
                    $display("%0t: unexpected frame, expected none, actual %h", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = mix_queue.pop_front();
                    if (got.left !== want.left) begin
                        $display("%0t: out_left expected %0d actual %0d",
                                 $realtime, want.left, got.left);
                        o_fail_count <= o_fail_count + 1;
                    end else if (got.right !== want.right) begin
                        $display("%0t: out_right expected %0d actual %0d",
                                 $realtime, want.right, got.right);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= mix_queue.size();
    end

endmodule

// File: dv/multi_source_audio_mixer_tb.sv
// Testbench top for the audio mixer: drives register writes, pushes and renders with
// random gaps and output stalls. Depends on msam_pkg, msam_mix_checker and the RTL.
`timescale 1ns / 1ps

module multi_source_audio_mixer_tb;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending, frames_seen;
    bit          hold_off, no_stall;
    int          pushes, renders;

    multi_source_audio_mixer DUT (.*);

    msam_mix_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending), .o_frames_seen(frames_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[multi_source_audio_mixer] ERROR");
        $finish;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    // Receiver: random stalls, or a long hold-off or no stalls when asked
    initial begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (no_stall) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                g = gap_len();
                if (g > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one item and hold it until the transfer
    task automatic send_item(logic op, logic [1:0] src, logic [31:0] l, logic [31:0] r,
                             bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, r, l, src, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == msam_pkg::OP_PUSH) pushes++; else renders++;
    endtask

    // Wait for all expected frames, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_sample(bit is_float);
        case ($urandom_range(0, 5))
            0: return is_float ? 32'h3F800000 : 32'h00007FFF;
            1: return is_float ? 32'hBF800000 : 32'hFFFF8000;
            2: return is_float ? {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'd126, 23'($urandom)}
                               : $urandom;
            3: return is_float ? {1'($urandom), 8'($urandom_range(100, 130)), 23'($urandom)}
                               : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Random phase: mostly pushes to random sources, with renders mixed in
    task automatic random_phase(int n, logic [3:0] fmask);
        logic [1:0] src;
        for (int i = 0; i < n; i++) begin
            src = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0)
                send_item(msam_pkg::OP_RENDER, 2'($urandom), $urandom, $urandom, 1'b1);
            else
                send_item(msam_pkg::OP_PUSH, src, rand_sample(fmask[src]),
                          rand_sample(fmask[src]), 1'b1);
        end
        drain();
    endtask

    initial begin
        logic [31:0] dir_vals[12];
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        hold_off = 1'b0; no_stall = 1'b0;
        pushes = 0; renders = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Render before any source is open: silence
        send_item(msam_pkg::OP_RENDER, 2'd0, '0, '0, 1'b0);
        // Push to a closed source is dropped
        send_item(msam_pkg::OP_PUSH, 2'd2, 32'h1234, 32'h5678, 1'b0);
        drain();

        // Directed: s16 on 0 and 1, float on 2, mono s16 on 3
        write_reg(msam_pkg::REG_FLOAT, 32'h4);
        write_reg(msam_pkg::REG_MONO, 32'h8);
        write_reg(msam_pkg::REG_ACTIVE, 32'hF);
        write_reg(msam_pkg::REG_RATIO3, 32'h1FFFFF);   // saturates to the top ratio
        dir_vals = '{32'h3F800000, 32'hBF800000, 32'h7F800000, 32'hFF800000,
                     32'h7FC00000, 32'h00000001, 32'h3F000000, 32'h38000000,
                     32'h37800000, 32'h38400000, 32'hFFFF7FFF, 32'h00008000};
        send_item(msam_pkg::OP_PUSH, 2'd0, 32'hFFFF7FFF, 32'h00008000, 1'b0);
        send_item(msam_pkg::OP_PUSH, 2'd1, 32'h00007FFF, 32'hABCD8000, 1'b0);
        for (int i = 0; i < 10; i++)
            send_item(msam_pkg::OP_PUSH, 2'd2, dir_vals[i], dir_vals[11 - i], 1'b0);
        send_item(msam_pkg::OP_PUSH, 2'd3, 32'h3F800000, 32'h0, 1'b0);
        for (int i = 0; i < 8; i++)
            send_item(msam_pkg::OP_RENDER, 2'd0, '0, '0, 1'b0);
        drain();

        // Ratio zero drops all frames; closing clears the rings
        write_reg(msam_pkg::REG_RATIO0, 32'd0);
        send_item(msam_pkg::OP_PUSH, 2'd0, 32'h100, 32'h100, 1'b0);
        send_item(msam_pkg::OP_RENDER, 2'd0, '0, '0, 1'b0);
        drain();
        write_reg(msam_pkg::REG_ACTIVE, 32'h0);
        write_reg(msam_pkg::REG_ACTIVE, 32'hF);

        // Random phases over several settings
        write_reg(msam_pkg::REG_RATIO0, 32'd65536);
        write_reg(msam_pkg::REG_RATIO1, 32'd32768);
        write_reg(msam_pkg::REG_RATIO2, 32'd98304);
        write_reg(msam_pkg::REG_RATIO3, 32'd1);
        write_reg(msam_pkg::REG_FLOAT, 32'h0);
        write_reg(msam_pkg::REG_MONO, 32'h0);
        random_phase(170, 4'h0);

        write_reg(msam_pkg::REG_FLOAT, 32'hF);
        write_reg(msam_pkg::REG_MONO, 32'h5);
        write_reg(msam_pkg::REG_RATIO3, 32'd1048576);
        write_reg(msam_pkg::REG_RATIO1, 32'd131072);
        random_phase(170, 4'hF);

        // Long receiver hold-off with the sender still offering renders
        hold_off = 1'b1;
        for (int i = 0; i < 20; i++)
            send_item(msam_pkg::OP_RENDER, 2'd0, '0, '0, 1'b0);
        drain();

        write_reg(msam_pkg::REG_FLOAT, 32'h3);
        write_reg(msam_pkg::REG_MONO, 32'hA);
        write_reg(msam_pkg::REG_ACTIVE, 32'h6);
        write_reg(msam_pkg::REG_RATIO2, 32'd40000);
        random_phase(170, 4'h3);

        write_reg(msam_pkg::REG_ACTIVE, 32'hF);
        write_reg(msam_pkg::REG_RATIO0, 32'd70000);
        no_stall = 1'b1;
        random_phase(70, 4'h3);
        no_stall = 1'b0;
        random_phase(100, 4'h3);

        $display("Covered %0d pushes and %0d renders, %0d mixed frames checked,",
                 pushes, renders, frames_seen);
        $display("s16/float/mono formats, ratio extremes, source close and output stalls.");
        if (fail_count == 0 && pending == 0)
            $display("[multi_source_audio_mixer] OK");
        else
            $display("[multi_source_audio_mixer] ERROR");
        $finish;
    end

endmodule
